[hdl/rr_pkg.sv]
// Package: shared constants and codes for the rectangle rasterizer.
`default_nettype none
package rr_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DIM_W      = 9;
  localparam int Q_W        = 19;
  localparam int EDGE_W     = 21;
  localparam int FRAC_W     = 8;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
  localparam logic signed [EDGE_W-1:0] ONE_Q8 = EDGE_W'(256);

  localparam logic [7:0] KIND_FILLED  = 8'd82;
  localparam logic [7:0] KIND_OUTLINE = 8'd114;
  localparam logic [7:0] BG_RESET     = 8'd32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG     = 2'd2;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [7:0]            wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } ram_req_t;
endpackage
`default_nettype wire

[hdl/rr_if.sv]
// Interfaces: command, response and configuration channels.
`default_nettype none
interface rr_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [18:0] rect_x;
  logic signed [18:0] rect_y;
  logic signed [18:0] rect_width;
  logic signed [18:0] rect_height;
  logic [7:0]        rect_kind;
  logic [7:0]        paint_char;
  logic [7:0]        read_col;
  logic [7:0]        read_row;
  modport source (output valid, op, rect_x, rect_y, rect_width, rect_height,
                  rect_kind, paint_char, read_col, read_row, input ready);
  modport sink (input valid, op, rect_x, rect_y, rect_width, rect_height,
                rect_kind, paint_char, read_col, read_row, output ready);
endinterface

interface rr_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] cell_char;
  modport source (output valid, status, cell_char, input ready);
  modport sink (input valid, status, cell_char, output ready);
endinterface

interface rr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/rr_canvas_ram.sv]
// Canvas memory: one write port, one registered read port.
`default_nettype none
module rr_canvas_ram (
  input  wire logic            clk,
  input  wire rr_pkg::ram_req_t req,
  output logic [7:0]           rdata
);
  import rr_pkg::*;

  logic [7:0] mem [MAX_WIDTH*MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
`default_nettype wire

[hdl/rectangle_rasterizer.sv]
// Top level: character framebuffer with rectangle clear, draw and read.
// Clear and draw sweep one cell per cycle, set by the single canvas write
// port; an empty canvas, a bad rectangle, an out-of-range read or an unknown
// op skips the sweep and the read and goes straight to the response.
// One command at a time: a new command is taken while the previous response
// waits. Synchronous reset clears control state and sets width and height to
// zero and the background to BG_RESET; canvas contents are undefined.
`default_nettype none
module rectangle_rasterizer (
  input wire logic clk,
  input wire logic rst,
  rr_cmd_if.sink   cmd,
  rr_rsp_if.source rsp,
  rr_cfg_if.sink   cfg
);
  import rr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0] canvas_width, canvas_height;
  logic [7:0]       background_char;
  logic [DIM_W-1:0] w_used, h_used;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             sweep_clear, filled;
  logic [7:0]       paint;
  logic signed [EDGE_W-1:0] rx, ry, right, bottom, rx_b, ry_b, right_b, bottom_b;
  logic             res_status;
  logic [7:0]       res_char;
  logic             out_valid, out_status;
  logic [7:0]       out_char;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  logic accept, slot_free, empty, rect_ok, rd_ok;
  logic signed [EDGE_W-1:0] px, py;
  logic covered, border, last_col, last_row;
  logic signed [EDGE_W-1:0] in_x, in_y, in_r, in_b;

  assign w_used = (canvas_width > MAX_W_DIM) ? MAX_W_DIM : canvas_width;
  assign h_used = (canvas_height > MAX_H_DIM) ? MAX_H_DIM : canvas_height;
  assign empty  = (w_used == '0) || (h_used == '0);

  assign cmd.ready = (state == ST_IDLE) && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign slot_free = !out_valid || rsp.ready;

  assign in_x = EDGE_W'(cmd.rect_x);
  assign in_y = EDGE_W'(cmd.rect_y);
  assign in_r = in_x + EDGE_W'(cmd.rect_width);
  assign in_b = in_y + EDGE_W'(cmd.rect_height);

  assign rect_ok = !cmd.rect_width[Q_W-1] && (cmd.rect_width != '0) &&
                   !cmd.rect_height[Q_W-1] && (cmd.rect_height != '0) &&
                   ((cmd.rect_kind == KIND_FILLED) || (cmd.rect_kind == KIND_OUTLINE));
  assign rd_ok = ({1'b0, cmd.read_col} < w_used) && ({1'b0, cmd.read_row} < h_used);

  assign px = $signed({{(EDGE_W-COL_W-FRAC_W){1'b0}}, col, {FRAC_W{1'b0}}});
  assign py = $signed({{(EDGE_W-ROW_W-FRAC_W){1'b0}}, row, {FRAC_W{1'b0}}});
  assign covered = (px >= rx) && (py >= ry) && (px <= right) && (py <= bottom);
  assign border = covered && ((px < rx_b) || (py < ry_b) || (px > right_b) ||
                              (py > bottom_b));
  assign last_col = ({1'b0, col} + DIM_W'(1)) == w_used;
  assign last_row = ({1'b0, row} + DIM_W'(1)) == h_used;

  always_comb begin
    ram_req.we    = (state == ST_SWEEP) && (sweep_clear || border || (covered && filled));
    ram_req.waddr = {row, col};
    ram_req.wdata = sweep_clear ? background_char : paint;
    ram_req.re    = accept && (cmd.op == OP_READ) && rd_ok;
    ram_req.raddr = {cmd.read_row, cmd.read_col};
  end

  rr_canvas_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (cmd.op == OP_CLEAR) begin
            state_next = empty ? ST_DONE : ST_SWEEP;
          end else if (cmd.op == OP_DRAW) begin
            state_next = (rect_ok && !empty) ? ST_SWEEP : ST_DONE;
          end else if (cmd.op == OP_READ) begin
            state_next = rd_ok ? ST_READ : ST_DONE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SWEEP: begin
        if (last_col && last_row) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      canvas_width    <= '0;
      canvas_height   <= '0;
      background_char <= BG_RESET;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_WIDTH:  canvas_width    <= cfg.data;
          REG_HEIGHT: canvas_height   <= cfg.data;
          REG_BG:     background_char <= cfg.data[7:0];
          default: ;
        endcase
      end
      if (state == ST_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (accept) begin
      col         <= '0;
      row         <= '0;
      sweep_clear <= (cmd.op == OP_CLEAR);
      filled      <= (cmd.rect_kind == KIND_FILLED);
      paint       <= cmd.paint_char;
      rx          <= in_x;
      ry          <= in_y;
      right       <= in_r;
      bottom      <= in_b;
      rx_b        <= in_x + ONE_Q8;
      ry_b        <= in_y + ONE_Q8;
      right_b     <= in_r - ONE_Q8;
      bottom_b    <= in_b - ONE_Q8;
      res_char    <= '0;
      priority if (cmd.op == OP_CLEAR) begin
        res_status <= 1'b0;
      end else if (cmd.op == OP_DRAW) begin
        res_status <= !rect_ok;
      end else if (cmd.op == OP_READ) begin
        res_status <= !rd_ok;
      end else begin
        res_status <= 1'b1;
      end
    end else if (state == ST_SWEEP) begin
      if (last_col) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end else if (state == ST_READ) begin
      res_char <= ram_rdata;
    end
    if (state == ST_DONE && slot_free) begin
      out_status <= res_status;
      out_char   <= res_char;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.cell_char = out_char;
endmodule
`default_nettype wire

[bench/testbench.sv]
// Testbench: self-checking stimulus and scoreboard for the rectangle rasterizer.
`default_nettype none
module testbench;
  import rr_pkg::*;

  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [1:0]         op;
    logic signed [18:0] rect_x;
    logic signed [18:0] rect_y;
    logic signed [18:0] rect_width;
    logic signed [18:0] rect_height;
    logic [7:0]         rect_kind;
    logic [7:0]         paint_char;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } cmd_t;

  typedef struct {
    logic       status;
    logic [7:0] cell_char;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rr_cmd_if cmd_ch ();
  rr_rsp_if rsp_ch ();
  rr_cfg_if cfg_ch ();

  rectangle_rasterizer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #2 clk = ~clk;

  // model state
  logic [7:0] canvas_model [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [8:0] width_reg;
  logic [8:0] height_reg;
  logic [7:0] bg_reg;
  rsp_t       expected_rsp [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_cycles  = 0;
  int fail_count   = 0;
  int idle_cycles  = 0;

  function automatic int cols_in_use();
    return (width_reg > MAX_W_DIM) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int rows_in_use();
    return (height_reg > MAX_H_DIM) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  // Applies one command to the model canvas and returns its response.
  function automatic rsp_t rasterize(cmd_t c);
    rsp_t   res;
    int     w;
    int     h;
    longint rx, ry, rw, rh, right, bottom, px, py;
    bit     covered, border;
    w = cols_in_use();
    h = rows_in_use();
    res.status = 1'b0;
    res.cell_char = 8'h00;
    case (c.op)
      OP_CLEAR: begin
        for (int r = 0; r < h; r++)
          for (int col = 0; col < w; col++)
            canvas_model[r*MAX_WIDTH + col] = bg_reg;
      end
      OP_DRAW: begin
        rx = c.rect_x;
        ry = c.rect_y;
        rw = c.rect_width;
        rh = c.rect_height;
        if (rw <= 0 || rh <= 0 ||
            (c.rect_kind != KIND_FILLED && c.rect_kind != KIND_OUTLINE)) begin
          res.status = 1'b1;
        end else begin
          right  = rx + rw;
          bottom = ry + rh;
          for (int r = 0; r < h; r++) begin
            py = longint'(r) * 256;
            for (int col = 0; col < w; col++) begin
              px = longint'(col) * 256;
              covered = px >= rx && py >= ry && px <= right && py <= bottom;
              border = covered && (px - rx < 256 || py - ry < 256 ||
                                   right - px < 256 || bottom - py < 256);
              if (border || (covered && c.rect_kind == KIND_FILLED))
                canvas_model[r*MAX_WIDTH + col] = c.paint_char;
            end
          end
        end
      end
      OP_READ: begin
        if (int'(c.read_col) >= w || int'(c.read_row) >= h)
          res.status = 1'b1;
        else
          res.cell_char = canvas_model[int'(c.read_row)*MAX_WIDTH + int'(c.read_col)];
      end
      default: res.status = 1'b1;
    endcase
    return res;
  endfunction

  task automatic note_mismatch(string what, rsp_t exp_r, logic act_status,
                               logic [7:0] act_cell);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("mismatch (%s): expected status %0d cell_char %02h, %s %0d cell_char %02h",
               what, exp_r.status, exp_r.cell_char, "got status", act_status, act_cell);
  endtask

  // Monitor: response check first, then the command and register beats of this edge.
  always @(posedge clk) begin
    rsp_t exp_r;
    cmd_t c;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          exp_r.status = 1'bx;
          exp_r.cell_char = 8'hxx;
          note_mismatch("no response expected", exp_r, rsp_ch.status, rsp_ch.cell_char);
        end else begin
          exp_r = expected_rsp.pop_front();
          if (rsp_ch.status !== exp_r.status || rsp_ch.cell_char !== exp_r.cell_char)
            note_mismatch("field", exp_r, rsp_ch.status, rsp_ch.cell_char);
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        c.op          = cmd_ch.op;
        c.rect_x      = cmd_ch.rect_x;
        c.rect_y      = cmd_ch.rect_y;
        c.rect_width  = cmd_ch.rect_width;
        c.rect_height = cmd_ch.rect_height;
        c.rect_kind   = cmd_ch.rect_kind;
        c.paint_char  = cmd_ch.paint_char;
        c.read_col    = cmd_ch.read_col;
        c.read_row    = cmd_ch.read_row;
        expected_rsp.push_back(rasterize(c));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_WIDTH:  width_reg  = cfg_ch.data;
          REG_HEIGHT: height_reg = cfg_ch.data;
          REG_BG:     bg_reg     = cfg_ch.data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Response sink with random stalls and requested hold-offs.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op          = 2'($urandom);
    c.rect_x      = 19'($urandom);
    c.rect_y      = 19'($urandom);
    c.rect_width  = 19'($urandom);
    c.rect_height = 19'($urandom);
    c.rect_kind   = 8'($urandom);
    c.paint_char  = 8'($urandom);
    c.read_col    = 8'($urandom);
    c.read_row    = 8'($urandom);
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_cmd(cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.op          <= c.op;
    cmd_ch.rect_x      <= c.rect_x;
    cmd_ch.rect_y      <= c.rect_y;
    cmd_ch.rect_width  <= c.rect_width;
    cmd_ch.rect_height <= c.rect_height;
    cmd_ch.rect_kind   <= c.rect_kind;
    cmd_ch.paint_char  <= c.paint_char;
    cmd_ch.read_col    <= c.read_col;
    cmd_ch.read_row    <= c.read_row;
    cmd_ch.valid       <= 1'b1;
    forever begin
      @(posedge clk);
      if (cmd_ch.ready) break;
    end
    @(negedge clk);
  endtask

  task automatic send_op(logic [1:0] op);
    cmd_t c;
    c = random_cmd();
    c.op = op;
    send_cmd(c);
  endtask

  task automatic send_draw(int x, int y, int w, int h, logic [7:0] kind, logic [7:0] paint);
    cmd_t c;
    c = random_cmd();
    c.op          = OP_DRAW;
    c.rect_x      = 19'(x);
    c.rect_y      = 19'(y);
    c.rect_width  = 19'(w);
    c.rect_height = 19'(h);
    c.rect_kind   = kind;
    c.paint_char  = paint;
    send_cmd(c);
  endtask

  task automatic send_read(int col, int row);
    cmd_t c;
    c = random_cmd();
    c.op       = OP_READ;
    c.read_col = 8'(col);
    c.read_row = 8'(row);
    send_cmd(c);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      cfg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_canvas(logic [8:0] w, logic [8:0] h, logic [8:0] bg);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_BG, bg);
  endtask

  // Zero-size canvas right after reset: nothing is touched, reads fail.
  task automatic test_reset_state();
    write_reg(REG_UNUSED, 9'h1FF);
    send_op(OP_CLEAR);
    send_draw(0, 0, 4*256, 4*256, KIND_FILLED, 8'h41);
    send_read(0, 0);
    send_op(OP_NONE);
    wait_drained();
  endtask

  // Oversized registers clamp to the full canvas; one clear writes every cell.
  task automatic test_full_canvas();
    set_canvas(9'h1FF, 9'd300, 9'h1FF);
    send_op(OP_CLEAR);
    send_read(0, 0);
    send_read(255, 255);
    send_draw(0, 0, 262143, 262143, KIND_OUTLINE, 8'h23);
    send_read(0, 5);
    send_read(5, 5);
    send_read(255, 0);
    wait_drained();
  endtask

  task automatic test_directed_draws();
    set_canvas(9'd16, 9'd12, 9'h000);
    send_op(OP_CLEAR);
    send_draw(640, 256, 1344, 768, KIND_FILLED, 8'hFF);
    send_draw(-384, -192, 8*256, 6*256, KIND_OUTLINE, 8'h6F);
    send_draw(10*256, 0, 256, 4*256, KIND_FILLED, 8'h00);
    send_draw(0, 0, 0, 256, KIND_FILLED, 8'h55);
    send_draw(0, 0, 256, -262144, KIND_OUTLINE, 8'h55);
    send_draw(0, 0, 4*256, 4*256, 8'h78, 8'h55);
    send_draw(-262144, -262144, 262143, 262143, KIND_FILLED, 8'h2A);
    send_draw(262143, 262143, 262143, 262143, KIND_FILLED, 8'h2A);
    send_read(16, 0);
    send_read(0, 255);
    send_read(3, 2);
    send_read(15, 11);
    wait_drained();
  endtask

  // Sink holds off while reads keep coming, so the command side backs up.
  task automatic test_backpressure();
    hold_cycles  = HOLD_CYCLES;
    repeat (12) send_read($urandom_range(15), $urandom_range(11));
    wait_drained();
  endtask

  task automatic send_random_item();
    cmd_t c;
    int   sel;
    int   w;
    int   h;
    c = random_cmd();
    w = cols_in_use();
    h = rows_in_use();
    sel = $urandom_range(99);
    if (sel < 10) begin
      c.op = OP_CLEAR;
    end else if (sel < 55) begin
      c.op          = OP_DRAW;
      c.rect_kind   = $urandom_range(1) ? KIND_FILLED : KIND_OUTLINE;
      c.rect_x      = 19'(int'($urandom_range((w + 4) * 256)) - 512);
      c.rect_y      = 19'(int'($urandom_range((h + 4) * 256)) - 512);
      c.rect_width  = 19'($urandom_range((w + 2) * 256, 1));
      c.rect_height = 19'($urandom_range((h + 2) * 256, 1));
    end else if (sel < 63) begin
      c.op = OP_DRAW;
    end else if (sel < 70) begin
      c.op        = OP_DRAW;
      c.rect_kind = $urandom_range(1) ? KIND_FILLED : KIND_OUTLINE;
      if ($urandom_range(1))
        c.rect_width = 19'(-int'($urandom_range(300)));
      else
        c.rect_height = 19'(-int'($urandom_range(300)));
    end else if (sel < 95) begin
      c.op = OP_READ;
      if ($urandom_range(3) != 0) begin
        c.read_col = 8'($urandom_range(w - 1));
        c.read_row = 8'($urandom_range(h - 1));
      end
    end else begin
      c.op = OP_NONE;
    end
    send_cmd(c);
  endtask

  task automatic test_random(int src_pct, int snk_pct, logic [8:0] w, logic [8:0] h, int n);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    set_canvas(w, h, 9'($urandom));
    send_op(OP_CLEAR);
    repeat (n) send_random_item();
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < MAX_WIDTH*MAX_HEIGHT; i++) canvas_model[i] = 8'h00;
    width_reg  = '0;
    height_reg = '0;
    bg_reg     = BG_RESET;
    cmd_ch.valid       = 1'b0;
    cmd_ch.op          = OP_CLEAR;
    cmd_ch.rect_x      = '0;
    cmd_ch.rect_y      = '0;
    cmd_ch.rect_width  = '0;
    cmd_ch.rect_height = '0;
    cmd_ch.rect_kind   = '0;
    cmd_ch.paint_char  = '0;
    cmd_ch.read_col    = '0;
    cmd_ch.read_row    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_WIDTH;
    cfg_ch.data        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct = 37;
    snk_idle_pct = 55;
    test_reset_state();
    test_full_canvas();
    test_directed_draws();
    test_backpressure();

    test_random(37, 55, 9'($urandom_range(48, 1)), 9'($urandom_range(48, 1)), 21);
    test_random(55, 37, 9'd1, 9'($urandom_range(48, 1)), 20);
    test_random(0, 0, 9'($urandom_range(48, 1)), 9'($urandom_range(48, 1)), 21);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_rsp.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hdl/rr_pkg.sv
hdl/rr_if.sv
hdl/rr_canvas_ram.sv
hdl/rectangle_rasterizer.sv
bench/testbench.sv
